// File: rtl/core/osset_pkg.sv
// Shared types and constants for the order-statistic set.
`default_nettype none
package osset_pkg;

	localparam int KEY_W   = 32;
	localparam int RANK_W  = 8;
	localparam int COUNT_W = 7;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Per-cell compare result, handed to the neighbor and the top level.
	typedef struct packed {
		logic gt;
		logic eq;
	} cell_flags_t;

endpackage
`default_nettype wire

// File: rtl/core/osset_cell.sv
// One slot of the sorted chain: holds a key, compares it, shifts up on insert.
`default_nettype none
module osset_cell #(
	parameter int IDX = 0,
	parameter int AW  = 9
) (
	input  wire                          clk,
	input  wire                          cmp_en,
	input  wire                          shift_en,
	input  wire  [osset_pkg::KEY_W-1:0]  kin,
	input  wire  [AW-1:0]                cnt,
	input  wire  [AW-1:0]                rank,
	input  wire  [osset_pkg::KEY_W-1:0]  prev_key,
	input  osset_pkg::cell_flags_t       prev_flags,
	output logic [osset_pkg::KEY_W-1:0]  key_q,
	output osset_pkg::cell_flags_t       flags_q,
	output logic [osset_pkg::KEY_W-1:0]  pick_q
);
	import osset_pkg::*;

	localparam logic [AW-1:0] IDX_V  = AW'(IDX);
	localparam logic [AW-1:0] IDX_P1 = AW'(IDX + 1);

	logic occupied;

	assign occupied = IDX_V < cnt;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			// empty slots act as +infinity so the insert point is the first gt slot
			flags_q.gt <= !occupied || ($signed(key_q) > $signed(kin));
			flags_q.eq <= occupied && (key_q == kin);
			pick_q     <= (rank == IDX_P1) ? key_q : '0;
		end
		if (shift_en && flags_q.gt) begin
			key_q <= prev_flags.gt ? prev_key : kin;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/order_statistic_set_core.sv
// Top level of the order-statistic set: command port, control and the cell chain.
//
// Bounded sorted set of distinct signed 32-bit keys held in a chain of CAPACITY
// cells. Each word passes through the accept edge, a compare state in which every
// cell compares its key against the word in parallel, and an update state in
// which the duplicate/full checks and the query read are reduced and an insert
// shifts the larger keys up one cell. busy is high in the compare and update
// states; done pulses for one cycle with status, value and count registered
// from the update state. A new word may be started during that pulse, but not
// before it. Results cannot be stalled: the receiver must take each one in its
// done cycle. count carries the low 7 bits of the number of keys held.
`default_nettype none
module order_statistic_set_core #(
	parameter int CAPACITY = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire                                func,
	input  wire  signed [osset_pkg::KEY_W-1:0] key,
	input  wire  [osset_pkg::RANK_W-1:0]       rank,
	output logic                               done,
	output logic [1:0]                         status,
	output logic signed [osset_pkg::KEY_W-1:0] value,
	output logic [osset_pkg::COUNT_W-1:0]      count
);
	import osset_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = ((CW > RANK_W) ? CW : RANK_W) + 1;

	state_t state_q, state_d;

	logic              func_q;
	logic [KEY_W-1:0]  key_q;
	logic [RANK_W-1:0] rank_q;
	logic [CW-1:0]     cnt_q;

	logic [KEY_W-1:0]  cell_key  [CAPACITY];
	cell_flags_t       cell_flag [CAPACITY];
	logic [KEY_W-1:0]  cell_pick [CAPACITY];

	logic             accept, cmp_en, upd, dup, full, bad_rank, do_ins;
	logic [KEY_W-1:0] pick_or;
	logic [AW-1:0]    cnt_ext, rank_ext;
	status_t          stat_d;
	logic [CW-1:0]    cnt_next;

	assign accept   = start && !busy;
	assign busy     = state_q != ST_IDLE;
	assign cmp_en   = state_q == ST_CMP;
	assign upd      = state_q == ST_UPD;
	assign cnt_ext  = AW'(cnt_q);
	assign rank_ext = AW'(rank_q);

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [KEY_W-1:0] pkey;
			cell_flags_t      pflag;
			if (g == 0) begin : g_head
				assign pkey  = key_q;
				assign pflag = '0;
			end else begin : g_link
				assign pkey  = cell_key[g-1];
				assign pflag = cell_flag[g-1];
			end
			osset_cell #(
				.IDX (g),
				.AW  (AW)
			) u_cell (
				.clk        (clk),
				.cmp_en     (cmp_en),
				.shift_en   (do_ins),
				.kin        (key_q),
				.cnt        (cnt_ext),
				.rank       (rank_ext),
				.prev_key   (pkey),
				.prev_flags (pflag),
				.key_q      (cell_key[g]),
				.flags_q    (cell_flag[g]),
				.pick_q     (cell_pick[g])
			);
		end
	endgenerate

	always_comb begin
		dup     = 1'b0;
		pick_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			dup     = dup | cell_flag[i].eq;
			pick_or = pick_or | cell_pick[i];
		end
	end

	assign full     = cnt_q == CW'(CAPACITY);
	assign bad_rank = (rank_q == '0) || (rank_ext > cnt_ext);
	assign do_ins   = upd && (func_q == FUNC_INSERT) && !dup && !full;
	assign cnt_next = do_ins ? cnt_q + CW'(1) : cnt_q;

	always_comb begin
		if (func_q == FUNC_QUERY) begin
			stat_d = bad_rank ? STAT_RANGE : STAT_OK;
		end else if (dup) begin
			stat_d = STAT_DUP;
		end else if (full) begin
			stat_d = STAT_FULL;
		end else begin
			stat_d = STAT_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CMP;
			end
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_next;
			done    <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key;
			rank_q <= rank;
		end
		if (upd) begin
			status <= stat_d;
			value  <= (func_q == FUNC_QUERY && !bad_rank) ? pick_or : '0;
			count  <= COUNT_W'(cnt_next);
		end
	end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for order_statistic_set_core: insert and k-th smallest queries.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import osset_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int RAND_WORDS = 680;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic                     func;
		logic signed [KEY_W-1:0]  key;
		logic [RANK_W-1:0]        rank;
	} set_word_t;

	typedef struct {
		status_t                  status;
		logic signed [KEY_W-1:0]  value;
		logic [COUNT_W-1:0]       count;
	} set_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     func = FUNC_INSERT;
	logic signed [KEY_W-1:0]  key = '0;
	logic [RANK_W-1:0]        rank = '0;
	wire                      busy;
	wire                      done;
	wire  [1:0]               status;
	wire  signed [KEY_W-1:0]  value;
	wire  [COUNT_W-1:0]       count;

	order_statistic_set_core #(.CAPACITY(CAPACITY)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .key(key), .rank(rank),
		.done(done), .status(status), .value(value), .count(count)
	);

	always #2 clk = ~clk;

	// Stimulus side
	set_word_t                word_q[$];
	logic signed [KEY_W-1:0]  sent_keys[$];
	bit                       sent_seen[int];
	int                       n_words = 0;
	int                       n_accepted = 0;

	// Shadow of the sorted store and expected results
	logic signed [KEY_W-1:0]  held_keys[CAPACITY];
	int                       held = 0;
	set_result_t              result_due_q[$];
	int                       n_stored = 0, n_dup = 0, n_full = 0, n_read = 0, n_range = 0;
	int                       n_mismatch = 0;
	int                       n_results = 0;

	task automatic queue_word(input logic f, input logic signed [KEY_W-1:0] k,
			input logic [RANK_W-1:0] r);
		set_word_t w;
		w.func = f;
		w.key  = k;
		w.rank = r;
		word_q.push_back(w);
		n_words++;
		if (f == FUNC_INSERT && !sent_seen.exists(k)) begin
			sent_seen[k] = 1'b1;
			sent_keys.push_back(k);
		end
	endtask

	// Applies one accepted word to the shadow set and queues its result.
	task automatic sorted_set_apply(input set_word_t w);
		set_result_t res;
		int pos;
		res.status = STAT_OK;
		res.value  = '0;
		if (w.func == FUNC_INSERT) begin
			pos = 0;
			while (pos < held && held_keys[pos] < w.key)
				pos++;
			if (pos < held && held_keys[pos] == w.key) begin
				res.status = STAT_DUP;
				n_dup++;
			end else if (held >= CAPACITY) begin
				res.status = STAT_FULL;
				n_full++;
			end else begin
				for (int i = held; i > pos; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[pos] = w.key;
				held++;
				n_stored++;
			end
		end else if (w.rank == 0 || w.rank > held) begin
			res.status = STAT_RANGE;
			n_range++;
		end else begin
			res.value = held_keys[w.rank-1];
			n_read++;
		end
		res.count = held[COUNT_W-1:0];
		result_due_q.push_back(res);
	endtask

	task automatic flag_mismatch(input string what);
		if (n_mismatch < 40)
			$display("[%0t] ERROR: %s", $time, what);
		n_mismatch++;
	endtask

	// Driver: bursts of words separated by random gaps
	int        burst_left = 1;
	int        gap_left = 0;
	set_word_t cur_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				sorted_set_apply(cur_word);
				n_accepted++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (word_q.size() > 0) begin
					cur_word = word_q.pop_front();
					func  <= cur_word.func;
					key   <= cur_word.key;
					rank  <= cur_word.rank;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
							: $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done pulse must match the oldest expected word
	always @(posedge clk) begin
		set_result_t exp_res;
		if (arst_n && done) begin
			n_results++;
			if (result_due_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result status %0d value %0d count %0d",
					status, value, count));
			end else begin
				exp_res = result_due_q.pop_front();
				if (status !== exp_res.status)
					flag_mismatch($sformatf("result %0d status %0d, expected %0d",
						n_results, status, exp_res.status));
				if (value !== exp_res.value)
					flag_mismatch($sformatf("result %0d value %0d, expected %0d",
						n_results, value, exp_res.value));
				if (count !== exp_res.count)
					flag_mismatch($sformatf("result %0d count %0d, expected %0d",
						n_results, count, exp_res.count));
			end
		end
	end

	// Watchdog: no accept and no result for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] timeout: no activity for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic signed [KEY_W-1:0] k;
		logic [RANK_W-1:0]       r;
		int                      live;

		// directed: empty set, extremes, duplicates, rank edges, ignored fields
		queue_word(FUNC_QUERY,  32'sh7FFF_FFFF, 8'd0);
		queue_word(FUNC_QUERY,  -32'sd1, 8'd1);
		queue_word(FUNC_INSERT, 32'sd0, 8'hFF);
		queue_word(FUNC_INSERT, 32'sh8000_0000, 8'd0);
		queue_word(FUNC_INSERT, 32'sh7FFF_FFFF, 8'd5);
		queue_word(FUNC_INSERT, -32'sd1, 8'd1);
		queue_word(FUNC_INSERT, 32'sd1, 8'd0);
		queue_word(FUNC_INSERT, 32'sd0, 8'd0);
		queue_word(FUNC_INSERT, 32'sh8000_0000, 8'd3);
		queue_word(FUNC_INSERT, 32'sh7FFF_FFFF, 8'd0);
		queue_word(FUNC_QUERY,  32'sd0, 8'd1);
		queue_word(FUNC_QUERY,  32'sh8000_0000, 8'd5);
		queue_word(FUNC_QUERY,  32'sd0, 8'd6);
		queue_word(FUNC_QUERY,  -32'sd1, 8'hFF);
		queue_word(FUNC_QUERY,  32'sd0, 8'd128);
		queue_word(FUNC_INSERT, 32'sh5555_5555, 8'hAA);
		queue_word(FUNC_INSERT, 32'shAAAA_AAAA, 8'h55);
		queue_word(FUNC_QUERY,  32'sh1234_5678, 8'd3);
		queue_word(FUNC_QUERY,  32'sd0, 8'd4);
		queue_word(FUNC_QUERY,  32'sd0, 8'd7);

		// random: fills the set over the first few hundred words, then runs full
		for (int i = 0; i < RAND_WORDS; i++) begin
			live = (sent_keys.size() < CAPACITY) ? sent_keys.size() : CAPACITY;
			if ($urandom_range(0, 99) < 28) begin
				case ($urandom_range(0, 9))
					0: k = int'($urandom_range(0, 16)) - 8;
					1: k = 32'sh8000_0000 + int'($urandom_range(0, 3));
					2: k = 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
					3, 4: k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
					5: k = sent_keys[$urandom_range(0, sent_keys.size() - 1)]
						+ (($urandom_range(0, 1) == 1) ? 1 : -1);
					default: k = $urandom;
				endcase
				queue_word(FUNC_INSERT, k, RANK_W'($urandom));
			end else begin
				case ($urandom_range(0, 19))
					0, 1: r = RANK_W'(live + 1);
					2: r = '0;
					3, 4: r = RANK_W'($urandom);
					default: r = (live == 0) ? RANK_W'(1) : RANK_W'($urandom_range(1, live));
				endcase
				queue_word(FUNC_QUERY, $urandom, r);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (n_accepted < n_words)
			@(posedge clk);
		while (result_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d words, %0d results: %0d keys stored, %0d duplicates, %0d dropped full",
			n_accepted, n_results, n_stored, n_dup, n_full);
		$display("Queries: %0d rank reads, %0d ranks out of range; final count %0d",
			n_read, n_range, held);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
